[rtl/scfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder package
// Shared types, constants and the CRC-16 byte update used by the decoder.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  SIGN_MASK  = 8'h80;
  localparam logic [7:0]  MAG_MASK   = 8'h7F;

  // Byte positions within the eight-byte reply.
  localparam logic [2:0]  POS_HUM_HI = 3'd2;
  localparam logic [2:0]  POS_HUM_LO = 3'd3;
  localparam logic [2:0]  POS_TMP_HI = 3'd4;
  localparam logic [2:0]  POS_TMP_LO = 3'd5;
  localparam logic [2:0]  POS_CRC_LO = 3'd6;
  localparam logic [2:0]  POS_CRC_HI = 3'd7;

  // Frame tracking and held measurement state.
  typedef struct packed {
    logic [2:0]  pos;
    logic [15:0] crc;
    logic [31:0] payload;
    logic [7:0]  rx_crc_lo;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } frame_state_t;

  // One result transaction.
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic [15:0] crc;
  } frame_result_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage : scfd_pkg
`default_nettype wire

[rtl/sensor_frame_crc_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder
// Checks the CRC-16 of an eight-byte humidity/temperature reply and holds
// the last good humidity and temperature readings.
//
// Usage:
//   Input stream: one reply byte per transaction on in_tdata; in_tuser high
//   marks byte 0 and restarts any partial frame. Without the mark the byte
//   position simply advances and wraps after byte 7.
//   Output stream: one transaction after each byte 7, carrying the check
//   flag on out_tuser and held humidity, held temperature and computed CRC
//   on out_tdata.
//   Throughput: one byte per cycle unless byte 7 must wait on out_tready.
//   Each byte is held in the input register, where the CRC byte update and
//   state update are done; when byte 7 leaves the input register its result
//   is registered in the output register and out_tvalid goes high.
//   Stall: while a result waits on out_tready, bytes that produce no result
//   keep flowing; only the next byte 7 waits in the input register.
//   Reset: position 0, CRC 0xFFFF, held readings zero, both channels empty.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tuser,   // [0] frame_start
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] humidity_tenths,
                                       // [31:16] temperature_tenths,
                                       // [47:32] computed_crc
  output logic             out_tuser   // [0] crc_ok
);
  import scfd_pkg::*;

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_start_r;
  frame_state_t  state_r;
  frame_state_t  state_nxt;
  logic          emit;
  frame_result_t result;
  frame_result_t out_res_r;
  logic          out_valid_r;
  logic          s1_advance;

  // Per-byte update logic.
  scfd_frame_core u_core (
    .state       (state_r),
    .frame_byte  (s1_byte_r),
    .frame_start (s1_start_r),
    .state_nxt   (state_nxt),
    .emit        (emit),
    .result      (result)
  );

  // The input stage moves on unless it holds a result the output cannot take.
  assign s1_advance = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Frame state, committed when the input stage moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.pos         <= 3'd0;
      state_r.crc         <= CRC_INIT;
      state_r.humidity    <= 16'd0;
      state_r.temperature <= 16'd0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_advance && emit) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.crc_ok;
  assign out_tdata  = {out_res_r.crc, out_res_r.temperature, out_res_r.humidity};

endmodule : sensor_frame_crc_decoder_top
`default_nettype wire

[rtl/scfd_frame_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder, per-byte update
// Combinational step: takes one byte and the current frame state, returns
// the next state and, after the last byte, the result transaction.
// ----------------------------------------------------------------------------
module scfd_frame_core (
  input  wire scfd_pkg::frame_state_t  state,
  input  wire logic [7:0]              frame_byte,
  input  wire logic                    frame_start,
  output scfd_pkg::frame_state_t       state_nxt,
  output logic                         emit,
  output scfd_pkg::frame_result_t      result
);
  import scfd_pkg::*;

  logic [2:0]  pos;
  logic [15:0] crc_cur;
  logic [15:0] crc_fed;
  logic [15:0] rx_crc;
  logic        ok;
  logic [14:0] mag;
  logic [15:0] temp_val;

  // A start mark restarts the frame before the byte is taken.
  assign pos      = frame_start ? 3'd0 : state.pos;
  assign crc_cur  = frame_start ? CRC_INIT : state.crc;
  assign crc_fed  = crc16_feed(crc_cur, frame_byte);
  assign rx_crc   = {frame_byte, state.rx_crc_lo};
  assign ok       = (rx_crc == crc_cur);

  // Sign-magnitude temperature to two's complement; negative zero gives zero.
  assign mag      = {state.payload[14:8] & MAG_MASK[6:0], state.payload[7:0]};
  assign temp_val = ((state.payload[15:8] & SIGN_MASK) != 8'h00)
                    ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  // Next state per byte position.
  always_comb begin
    state_nxt = state;
    emit      = 1'b0;
    if (pos <= POS_TMP_LO) begin
      state_nxt.crc = crc_fed;
      state_nxt.pos = pos + 3'd1;
      unique case (pos)
        POS_HUM_HI: state_nxt.payload[31:24] = frame_byte;
        POS_HUM_LO: state_nxt.payload[23:16] = frame_byte;
        POS_TMP_HI: state_nxt.payload[15:8]  = frame_byte;
        POS_TMP_LO: state_nxt.payload[7:0]   = frame_byte;
        default:    state_nxt.payload        = state.payload;
      endcase
    end else if (pos == POS_CRC_LO) begin
      state_nxt.crc       = crc_cur;
      state_nxt.rx_crc_lo = frame_byte;
      state_nxt.pos       = POS_CRC_HI;
    end else begin
      emit          = 1'b1;
      state_nxt.pos = 3'd0;
      state_nxt.crc = CRC_INIT;
      if (ok) begin
        state_nxt.humidity    = state.payload[31:16];
        state_nxt.temperature = temp_val;
      end
    end
  end

  // Result fields follow the updated held values.
  always_comb begin
    result.crc_ok      = ok;
    result.humidity    = state_nxt.humidity;
    result.temperature = state_nxt.temperature;
    result.crc         = crc_cur;
  end

endmodule : scfd_frame_core
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame CRC decoder testbench
// Streams eight-byte sensor replies into the decoder, mostly well-formed
// frames with random content and a share of corrupted, cut-off and noisy
// ones, under three back-pressure profiles. A scoreboard tracks the frame
// position, the running CRC-16 and the held readings, and compares each
// result transaction field by field with the next expected one.
// ----------------------------------------------------------------------------
module tb_top;
  import scfd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int BYTES_PER_PHASE = 560;
  localparam int SETTLE_CYCLES   = 8;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int cycle_count    = 0;

  // Tracks the decoder's frame state and keeps the results it must produce.
  class frame_checker;
    logic [2:0]    next_pos;
    logic [15:0]   running_crc;
    logic [31:0]   payload;
    logic [7:0]    crc_lo_byte;
    logic [15:0]   humidity;
    logic [15:0]   temperature;
    frame_result_t expected_results[$];
    int            error_count;

    function new();
      next_pos    = 3'd0;
      running_crc = CRC_INIT;
      payload     = 32'h0;
      crc_lo_byte = 8'h00;
      humidity    = 16'h0;
      temperature = 16'h0;
      error_count = 0;
    endfunction

    // Reflected CRC-16 step over one byte, least significant bit first.
    static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {8'h00, data};
      repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      return r;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the frame state by one accepted input transaction.
    function void take_byte(logic [7:0] data, logic start);
      logic [14:0]   magnitude;
      logic [15:0]   rx_crc;
      frame_result_t res;
      if (start) begin
        next_pos    = 3'd0;
        running_crc = CRC_INIT;
      end
      if (next_pos <= POS_TMP_LO) begin
        running_crc = crc_next(running_crc, data);
        case (next_pos)
          POS_HUM_HI: payload[31:24] = data;
          POS_HUM_LO: payload[23:16] = data;
          POS_TMP_HI: payload[15:8]  = data;
          POS_TMP_LO: payload[7:0]   = data;
          default: ;
        endcase
        next_pos = next_pos + 3'd1;
      end else if (next_pos == POS_CRC_LO) begin
        crc_lo_byte = data;
        next_pos    = POS_CRC_HI;
      end else begin
        // Last byte of the frame: compare CRCs and update held readings.
        rx_crc     = {data, crc_lo_byte};
        res.crc_ok = (rx_crc == running_crc);
        if (res.crc_ok) begin
          humidity  = payload[31:16];
          magnitude = {payload[14:8] & MAG_MASK[6:0], payload[7:0]};
          if ((payload[15:8] & SIGN_MASK) != 8'h00) begin
            temperature = 16'h0 - {1'b0, magnitude};
          end else begin
            temperature = {1'b0, magnitude};
          end
        end
        res.humidity    = humidity;
        res.temperature = temperature;
        res.crc         = running_crc;
        expected_results.push_back(res);
        next_pos    = 3'd0;
        running_crc = CRC_INIT;
      end
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(logic ok, logic [47:0] data);
      frame_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("Unexpected result transaction: crc_ok %0d, data %h", ok, data);
        error_count++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (ok !== exp_res.crc_ok) begin
        $error("crc_ok: expected %0d, actual %0d", exp_res.crc_ok, ok);
        error_count++;
      end
      if (data[15:0] !== exp_res.humidity) begin
        $error("humidity_tenths: expected %0d, actual %0d",
               exp_res.humidity, data[15:0]);
        error_count++;
      end
      if (data[31:16] !== exp_res.temperature) begin
        $error("temperature_tenths: expected %0d, actual %0d",
               $signed(exp_res.temperature), $signed(data[31:16]));
        error_count++;
      end
      if (data[47:32] !== exp_res.crc) begin
        $error("computed_crc: expected %h, actual %h", exp_res.crc, data[47:32]);
        error_count++;
      end
    endfunction
  endclass

  frame_checker frame_chk;

  sensor_frame_crc_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: check accepted transactions and stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        frame_chk.check_result(out_tuser, out_tdata);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one byte, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] data, input logic start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_chk.take_byte(data, start);
    bytes_sent++;
  endtask

  // Send the first len bytes of a reply; corrupt flips bits of the CRC.
  task automatic send_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                            input logic [15:0] hum, input logic [15:0] temp_raw,
                            input bit corrupt, input bit mark, input int len);
    logic [7:0]  fb [8];
    logic [15:0] crc;
    logic [15:0] flip;
    fb[0] = hdr0;
    fb[1] = hdr1;
    fb[2] = hum[15:8];
    fb[3] = hum[7:0];
    fb[4] = temp_raw[15:8];
    fb[5] = temp_raw[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = frame_checker::crc_next(crc, fb[i]);
    if (corrupt) begin
      flip = 16'($urandom_range(1, 16'hFFFF));
      crc  = crc ^ flip;
    end
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int i = 0; i < len; i++) send_byte(fb[i], (i == 0) && mark);
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_chk.pending() != 0) @(posedge clk);
  endtask

  // Directed frames: field extremes, negative zero, restart, bad CRC,
  // and a frame that follows without a start mark.
  task automatic run_directed();
    send_frame(8'hFF, 8'hFF, 16'hFFFF, 16'h8000, 1'b0, 1'b1, 8);
    send_frame(8'h03, 8'h04, 16'h1234, 16'h0155, 1'b0, 1'b1, 2);
    send_frame(8'h00, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 8);
    send_frame(8'h00, 8'hFF, 16'h0000, 16'h7FFF, 1'b1, 1'b0, 8);
    send_frame(8'hA5, 8'h5A, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 8);
  endtask

  // Mostly well-formed frames with random content, plus broken ones.
  task automatic run_random(input int count);
    int          stop_at;
    int          kind;
    bit          need_mark;
    logic [15:0] hum;
    logic [15:0] temp_raw;
    int          len;
    stop_at   = bytes_sent + count;
    need_mark = 1'b0;
    while (bytes_sent < stop_at) begin
      kind     = $urandom_range(0, 99);
      hum      = 16'($urandom);
      temp_raw = 16'($urandom);
      case ($urandom_range(0, 15))
        0: temp_raw = 16'h8000;
        1: temp_raw = 16'hFFFF;
        2: hum = 16'hFFFF;
        3: hum = 16'h0000;
        default: ;
      endcase
      if (kind < 70) begin
        send_frame(8'($urandom), 8'($urandom), hum, temp_raw, 1'b0,
                   need_mark || ($urandom_range(0, 4) != 0), 8);
        need_mark = 1'b0;
      end else if (kind < 80) begin
        send_frame(8'($urandom), 8'($urandom), hum, temp_raw, 1'b1,
                   need_mark || ($urandom_range(0, 4) != 0), 8);
        need_mark = 1'b0;
      end else if (kind < 90) begin
        // Frame cut off; the next one restarts with a start mark.
        len = $urandom_range(1, 7);
        send_frame(8'($urandom), 8'($urandom), hum, temp_raw, 1'b0, 1'b1, len);
        need_mark = 1'b1;
      end else begin
        // Line noise with stray start marks.
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        need_mark = 1'b1;
      end
    end
  endtask

  // Main sequence.
  initial begin
    frame_chk = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 16;
    recv_stall_pct = 81;
    run_directed();
    run_random(BYTES_PER_PHASE);
    drain_results();

    send_idle_pct  = 81;
    recv_stall_pct = 16;
    run_random(BYTES_PER_PHASE);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(BYTES_PER_PHASE);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_chk.pending() != 0) begin
      $error("%0d expected results never arrived", frame_chk.pending());
      frame_chk.error_count++;
    end
    if (frame_chk.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/scfd_pkg.sv
rtl/scfd_frame_core.sv
rtl/sensor_frame_crc_decoder_top.sv
tb/tb_top.sv
